FILE: hw/rtl/smrc_pkg.sv
// ----------------------------------------------------------------------------
// smrc_pkg
// Shared types and constants for the sorted multiset rank counter.
// ----------------------------------------------------------------------------
`default_nettype none

package smrc_pkg;

  localparam int CAPACITY = 256;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 9;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PAD_N    = 1 << IDX_W;
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_QUERY    = 2'd2
  } status_t;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  // what one cell hands to its right neighbor
  typedef struct packed {
    logic                      vld;
    logic                      le;
    logic signed [VALUE_W-1:0] val;
  } cell_link_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smrc_cell.sv
// ----------------------------------------------------------------------------
// smrc_cell
// One sorted slot: keeps, takes key or shifts right; latches lt on query.
// ----------------------------------------------------------------------------
`default_nettype none

module smrc_cell (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               ins_en,
  input  wire logic                               qry_en,
  input  wire logic signed [smrc_pkg::VALUE_W-1:0] key,
  input  wire smrc_pkg::cell_link_t               link_in,
  output smrc_pkg::cell_link_t                    link_out,
  output logic                                    lt_flag
);
  import smrc_pkg::*;

  logic                      vld_r, vld_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      lt_r, lt_nxt;
  logic                      le_self;
  logic                      lt_self;

  assign le_self = vld_r && (val_r <= key);
  assign lt_self = vld_r && (val_r < key);

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    lt_nxt  = lt_r;
    if (ins_en && !le_self) begin
      vld_nxt = vld_r | link_in.vld;
      val_nxt = link_in.le ? key : link_in.val;
    end
    if (qry_en) begin
      lt_nxt = lt_self;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    lt_r  <= lt_nxt;
  end

  assign link_out.vld = vld_r;
  assign link_out.le  = le_self;
  assign link_out.val = val_r;
  assign lt_flag      = lt_r;

endmodule

`default_nettype wire

FILE: hw/rtl/smrc_rank.sv
// ----------------------------------------------------------------------------
// smrc_rank
// Turns the thermometer of less-than flags along the chain into a count.
// ----------------------------------------------------------------------------
`default_nettype none

module smrc_rank (
  input  wire logic [smrc_pkg::CAPACITY-1:0] flags,
  output logic      [smrc_pkg::OCC_W-1:0]    rank
);
  import smrc_pkg::*;

  logic [PAD_N-1:0] therm;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] probe;

  always_comb begin
    therm = PAD_N'(flags);
    pos   = '0;
    probe = '0;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      probe = pos | IDX_W'((1 << k) - 1);
      if (therm[probe]) begin
        pos = pos | IDX_W'(1 << k);
      end
    end
    rank = OCC_W'(pos) + OCC_W'(therm[PAD_N-1]);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_multiset_rank_counter_top.sv
// ----------------------------------------------------------------------------
// sorted_multiset_rank_counter_top
// Bounded sorted multiset of signed values with rank queries.
//
//   channel  ports                     handshake
//   input    in_item                   start & !busy
//   result   out_item                  out_valid, one cycle, no stall
//
// On an accept the cell chain is updated (insert, unless full) or each cell's
// less-than flag is latched (query); the output register then takes the
// result, found by an 8-step search over the flag thermometer.
// busy is registered: it rises in the cycle after an accept, and no item is taken while it is high.
// Reset empties the store at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_multiset_rank_counter_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire smrc_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output smrc_pkg::out_item_t       out_item
);
  import smrc_pkg::*;

  logic               accept;
  logic               is_query;
  logic               full;
  logic               ins_en;
  logic               qry_en;
  logic               pend_r, pend_nxt;
  logic               qry_r, qry_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [OCC_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [OCC_W-1:0]   rank;
  logic [31:0]        count_wide;
  cell_link_t         links [CAPACITY+1];
  logic [CAPACITY-1:0] lt_flags;

  assign accept   = start && !pend_r;
  assign is_query = (in_item.op == OP_QUERY);
  assign full     = (occ_r >= OCC_W'(CAPACITY));
  assign ins_en   = accept && !is_query && !full;
  assign qry_en   = accept && is_query;

  assign links[0].vld = 1'b1;
  assign links[0].le  = 1'b0;
  assign links[0].val = in_item.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smrc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ins_en   (ins_en),
      .qry_en   (qry_en),
      .key      (in_item.value),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .lt_flag  (lt_flags[i])
    );
  end

  smrc_rank u_rank (
    .flags (lt_flags),
    .rank  (rank)
  );

  always_comb begin
    pend_nxt   = 1'b0;
    qry_nxt    = qry_r;
    status_nxt = status_r;
    occ_nxt    = occ_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      pend_nxt = 1'b1;
      qry_nxt  = is_query;
      if (is_query) begin
        status_nxt = ST_QUERY;
      end else if (full) begin
        status_nxt = ST_DROPPED;
        cnt_nxt    = occ_r;
      end else begin
        status_nxt = ST_INSERTED;
        occ_nxt    = occ_r + OCC_W'(1);
        cnt_nxt    = occ_r + OCC_W'(1);
      end
    end
  end

  always_comb begin
    count_wide           = 32'(qry_r ? rank : cnt_r);
    out_valid_nxt        = pend_r;
    out_item_nxt.status  = status_r;
    out_item_nxt.count   = count_wide[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qry_r      <= qry_nxt;
    status_r   <= status_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = pend_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_accept_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted item produced no result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_INSERTED) |-> (cnt_r == occ_r))
    else $error("insert count differs from occupancy");
`endif

endmodule

`default_nettype wire

FILE: bench/sorted_multiset_rank_counter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_multiset_rank_counter_top_test
// Sends insert and rank-query items to the multiset counter and checks every
// result, field by field, against a known table value or a queue model of
// the stored values. A short table of hand-picked items comes first, then
// random traffic fills the store until inserts drop, with random sender gaps.
// ----------------------------------------------------------------------------

module sorted_multiset_rank_counter_top_test;
  import smrc_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int DIR_N        = 24;

  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic                      known;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIR_N] = '{
    '{OP_QUERY,  32'sd0,            1'b1, ST_QUERY,    9'd0},
    '{OP_QUERY,  V_MIN,             1'b1, ST_QUERY,    9'd0},
    '{OP_QUERY,  V_MAX,             1'b1, ST_QUERY,    9'd0},
    '{OP_INSERT, V_MAX,             1'b1, ST_INSERTED, 9'd1},
    '{OP_INSERT, V_MIN,             1'b1, ST_INSERTED, 9'd2},
    '{OP_QUERY,  V_MIN,             1'b1, ST_QUERY,    9'd0},
    '{OP_QUERY,  V_MAX,             1'b1, ST_QUERY,    9'd1},
    '{OP_INSERT, 32'sd0,            1'b1, ST_INSERTED, 9'd3},
    '{OP_INSERT, 32'sd0,            1'b1, ST_INSERTED, 9'd4},
    '{OP_QUERY,  32'sd0,            1'b0, ST_QUERY,    9'd0},
    '{OP_QUERY,  32'sd1,            1'b0, ST_QUERY,    9'd0},
    '{OP_QUERY,  -32'sd1,           1'b0, ST_QUERY,    9'd0},
    '{OP_INSERT, -32'sd1,           1'b1, ST_INSERTED, 9'd5},
    '{OP_QUERY,  32'sd0,            1'b0, ST_QUERY,    9'd0},
    '{OP_INSERT, V_MAX,             1'b1, ST_INSERTED, 9'd6},
    '{OP_QUERY,  V_MAX,             1'b0, ST_QUERY,    9'd0},
    '{OP_INSERT, V_MIN,             1'b1, ST_INSERTED, 9'd7},
    '{OP_QUERY,  32'sh8000_0001,    1'b0, ST_QUERY,    9'd0},
    '{OP_QUERY,  V_MIN,             1'b1, ST_QUERY,    9'd0},
    '{OP_INSERT, 32'sh5555_5555,    1'b1, ST_INSERTED, 9'd8},
    '{OP_INSERT, 32'shAAAA_AAAA,    1'b1, ST_INSERTED, 9'd9},
    '{OP_QUERY,  32'sd0,            1'b0, ST_QUERY,    9'd0},
    '{OP_QUERY,  V_MAX,             1'b0, ST_QUERY,    9'd0},
    '{OP_INSERT, 32'sh7FFF_FFFE,    1'b1, ST_INSERTED, 9'd10}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  logic signed [VALUE_W-1:0] held_values[$];
  out_item_t                 pending_results[$];

  int errors     = 0;
  int n_inserted = 0;
  int n_dropped  = 0;
  int n_queries  = 0;

  sorted_multiset_rank_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic out_item_t multiset_step(in_item_t it);
    out_item_t                 r;
    logic signed [VALUE_W-1:0] v;
    int                        below;
    v = it.value;
    below = 0;
    if (it.op == OP_QUERY) begin
      foreach (held_values[k]) if (held_values[k] < v) below++;
      r.status = ST_QUERY;
      r.count  = COUNT_W'(below);
      n_queries++;
    end else if (held_values.size() >= CAPACITY) begin
      r.status = ST_DROPPED;
      r.count  = COUNT_W'(held_values.size());
      n_dropped++;
    end else begin
      held_values.push_back(v);
      r.status = ST_INSERTED;
      r.count  = COUNT_W'(held_values.size());
      n_inserted++;
    end
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned               r;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 5))
        0: v = V_MIN;
        1: v = V_MAX;
        2: v = 32'sd0;
        3: v = -32'sd1;
        4: v = V_MIN + 32'sd1;
        default: v = V_MAX - 32'sd1;
      endcase
    end else if (r < 35) begin
      v = int'($urandom_range(0, 8)) - 4;
    end else if (r < 60 && held_values.size() > 0) begin
      v = held_values[$urandom_range(0, held_values.size() - 1)]
          + int'($urandom_range(0, 2)) - 1;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic issue_item(in_item_t it, logic known, out_item_t typed, bit may_idle);
    out_item_t predicted;
    if (may_idle && $urandom_range(0, 99) < 24) begin
      start   <= 1'b0;
      in_item <= in_item_t'({1'($urandom), $urandom});
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = multiset_step(it);
    pending_results.push_back(known ? typed : predicted);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d count %0d",
                                  out_item.status, out_item.count));
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_item.status, want.status));
        if (out_item.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d (status %0d)",
                                    out_item.count, want.count, want.status));
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t typed;
    bit        paused;
    bit        drained_at_full;
    bit        full;
    drained_at_full = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[r]) begin
      it.op        = DIRECTED[r].op;
      it.value     = DIRECTED[r].value;
      typed.status = DIRECTED[r].status;
      typed.count  = DIRECTED[r].count;
      issue_item(it, DIRECTED[r].known, typed, 1'b1);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      full   = held_values.size() >= CAPACITY;
      paused = 1'b0;
      if (i == 500 || (full && !drained_at_full)) begin
        drained_at_full = drained_at_full | full;
        paused          = 1'b1;
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (!full && i >= 900)
        it.op = OP_INSERT;
      else
        it.op = ($urandom_range(0, 99) < (full ? 30 : 45)) ? OP_INSERT : OP_QUERY;
      it.value = pick_value();
      issue_item(it, 1'b0, '0, !paused && (i < 400 || i >= 650));
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);

    $display("covered %0d items: %0d inserts stored, %0d dropped on a full store, %0d queries",
             DIR_N + RANDOM_ITEMS, n_inserted, n_dropped, n_queries);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #500_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
